// ===== rtl/dnsx_pkg.sv =====
// dnsx_pkg: shared types, codes and constants of the dns answer address extractor
// no dependencies
`timescale 1ns / 1ps

package dnsx_pkg;

  localparam int COUNT_WIDTH_DEF = 16;

  localparam logic [15:0] TYPE_A    = 16'h0001;
  localparam logic [15:0] TYPE_AAAA = 16'h001c;
  localparam logic [7:0]  TAG_MASK  = 8'hff;

  typedef enum logic [1:0] {
    KIND_V4  = 2'd0,
    KIND_V6  = 2'd1,
    KIND_END = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_IP    = 4'd1,
    PH_UDP   = 4'd2,
    PH_DNSH  = 4'd3,
    PH_QLEN  = 4'd4,
    PH_QLAB  = 4'd5,
    PH_QTAIL = 4'd6,
    PH_RFIX  = 4'd7,
    PH_RDATA = 4'd8,
    PH_DONE  = 4'd9
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] set_tag;
    logic       first_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [7:0]  out_tag;
    logic        packet_done;
  } res_t;

endpackage

// ===== rtl/dnsx_if.sv =====
// dnsx_in_if, dnsx_out_if: valid/ready channels for packet bytes and extracted addresses
// no dependencies
`timescale 1ns / 1ps

interface dnsx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] set_tag;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, data_byte, set_tag, first_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, set_tag, first_byte, last_byte, output ready);
endinterface

interface dnsx_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic [7:0]  out_tag;
  logic        packet_done;

  modport source (output valid, kind, addr_high, addr_low, out_tag, packet_done, input ready);
  modport sink   (input valid, kind, addr_high, addr_low, out_tag, packet_done, output ready);
endinterface

// ===== rtl/dnsx_in_reg.sv =====
// dnsx_in_reg: input register stage for packet byte words
// depends on dnsx_pkg
`timescale 1ns / 1ps

module dnsx_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  dnsx_pkg::in_word_t in_word,
  output logic               in_ready,
  input  logic               advance,
  output logic               step,
  output dnsx_pkg::in_word_t word
);
  import dnsx_pkg::*;

  logic     valid_r;
  in_word_t word_r;

  assign in_ready = !valid_r || advance;
  assign step     = valid_r && advance;
  assign word     = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_word;
    end
  end

endmodule

// ===== rtl/dnsx_parser.sv =====
// dnsx_parser: per-byte header walk, answer record parse and address assembly
// depends on dnsx_pkg
`timescale 1ns / 1ps

module dnsx_parser #(
  parameter int COUNT_WIDTH = dnsx_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  dnsx_pkg::in_word_t word,
  output logic               res_valid,
  output dnsx_pkg::res_t     res
);
  import dnsx_pkg::*;

  localparam logic [15:0] CNT_MAX = 16'((64'd1 << COUNT_WIDTH) - 64'd1);
  localparam logic [COUNT_WIDTH-1:0] C0  = COUNT_WIDTH'(0);
  localparam logic [COUNT_WIDTH-1:0] C1  = COUNT_WIDTH'(1);
  localparam logic [COUNT_WIDTH-1:0] C2  = COUNT_WIDTH'(2);
  localparam logic [COUNT_WIDTH-1:0] C3  = COUNT_WIDTH'(3);
  localparam logic [COUNT_WIDTH-1:0] C4  = COUNT_WIDTH'(4);
  localparam logic [COUNT_WIDTH-1:0] C5  = COUNT_WIDTH'(5);
  localparam logic [COUNT_WIDTH-1:0] C6  = COUNT_WIDTH'(6);
  localparam logic [COUNT_WIDTH-1:0] C8  = COUNT_WIDTH'(8);
  localparam logic [COUNT_WIDTH-1:0] C9  = COUNT_WIDTH'(9);
  localparam logic [COUNT_WIDTH-1:0] C10 = COUNT_WIDTH'(10);
  localparam logic [COUNT_WIDTH-1:0] C12 = COUNT_WIDTH'(12);
  localparam logic [COUNT_WIDTH-1:0] C15 = COUNT_WIDTH'(15);
  localparam logic [COUNT_WIDTH-1:0] C16 = COUNT_WIDTH'(16);
  localparam logic [COUNT_WIDTH-1:0] C19 = COUNT_WIDTH'(19);
  localparam logic [COUNT_WIDTH-1:0] C39 = COUNT_WIDTH'(39);

  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [COUNT_WIDTH-1:0] ans_r, ans_nxt;
  logic [7:0]             ans_hi_r, ans_hi_nxt;
  logic [15:0]            qtype_r, qtype_nxt;
  logic [15:0]            rtype_r, rtype_nxt;
  logic [15:0]            rlen_r, rlen_nxt;
  logic [63:0]            acc_hi_r, acc_hi_nxt;
  logic [63:0]            acc_lo_r, acc_lo_nxt;
  logic [7:0]             tag_r, tag_nxt;

  logic [7:0]             b;
  logic [63:0]            shift_hi, shift_lo;
  logic [COUNT_WIDTH-1:0] cnt_dec, ans_dec, hlen_m1;
  logic [15:0]            rlen_dec, ans_raw;
  logic                   rdy4, rdy6;

  assign b        = word.data_byte;
  assign shift_hi = {acc_hi_r[55:0], acc_lo_r[63:56]};
  assign shift_lo = {acc_lo_r[55:0], b};
  assign cnt_dec  = cnt_r - C1;
  assign ans_dec  = ans_r - C1;
  assign rlen_dec = rlen_r - 16'd1;
  assign ans_raw  = {ans_hi_r, b};

  // ip header length minus one: ipv4 ihl below five taken as five, other versions 40 bytes (ipv6)
  always_comb begin
    if (b[7:4] == 4'd4) begin
      if (b[3:0] < 4'd5) begin
        hlen_m1 = C19;
      end else begin
        hlen_m1 = COUNT_WIDTH'({b[3:0], 2'b00}) - C1;
      end
    end else begin
      hlen_m1 = C39;
    end
  end

  assign rdy4 = !word.first_byte && phase_r == PH_RDATA && cnt_r == C3 && rtype_r == TYPE_A;
  assign rdy6 = !word.first_byte && phase_r == PH_RDATA && cnt_r == C15 &&
                rtype_r == TYPE_AAAA;

  // next state
  always_comb begin
    logic [15:0] qcur;
    logic [15:0] tcur;
    logic [15:0] lcur;
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    ans_nxt    = ans_r;
    ans_hi_nxt = ans_hi_r;
    qtype_nxt  = qtype_r;
    rtype_nxt  = rtype_r;
    rlen_nxt   = rlen_r;
    acc_hi_nxt = acc_hi_r;
    acc_lo_nxt = acc_lo_r;
    tag_nxt    = tag_r;
    qcur       = qtype_r;
    tcur       = rtype_r;
    lcur       = rlen_r;
    if (step) begin
      if (word.first_byte) begin
        tag_nxt   = word.set_tag & TAG_MASK;
        phase_nxt = PH_IP;
        cnt_nxt   = hlen_m1;
        ans_nxt   = C0;
      end else begin
        case (phase_r)
          PH_IP: begin
            cnt_nxt = cnt_dec;
            if (cnt_dec == C0) begin
              phase_nxt = PH_UDP;
              cnt_nxt   = C8;
            end
          end
          PH_UDP: begin
            cnt_nxt = cnt_dec;
            if (cnt_dec == C0) begin
              phase_nxt = PH_DNSH;
              cnt_nxt   = C12;
            end
          end
          PH_DNSH: begin
            if (cnt_r == C6) begin
              ans_hi_nxt = b;
            end
            if (cnt_r == C5) begin
              ans_nxt = (ans_raw > CNT_MAX) ? {COUNT_WIDTH{1'b1}} : ans_raw[COUNT_WIDTH-1:0];
            end
            cnt_nxt = cnt_dec;
            if (cnt_dec == C0) begin
              phase_nxt = PH_QLEN;
            end
          end
          PH_QLEN: begin
            if (b == 8'd0) begin
              phase_nxt = PH_QTAIL;
              cnt_nxt   = C4;
            end else begin
              phase_nxt = PH_QLAB;
              cnt_nxt   = COUNT_WIDTH'(b);
            end
          end
          PH_QLAB: begin
            cnt_nxt = cnt_dec;
            if (cnt_dec == C0) begin
              phase_nxt = PH_QLEN;
            end
          end
          PH_QTAIL: begin
            if (cnt_r == C4) begin
              qcur = {b, 8'h00};
            end
            if (cnt_r == C3) begin
              qcur = {qtype_r[15:8], b};
            end
            qtype_nxt = qcur;
            cnt_nxt   = cnt_dec;
            if (cnt_dec == C0) begin
              if (ans_r != C0 && (qcur == TYPE_A || qcur == TYPE_AAAA)) begin
                phase_nxt = PH_RFIX;
                cnt_nxt   = C12;
              end else begin
                phase_nxt = PH_DONE;
              end
            end
          end
          PH_RFIX: begin
            if (cnt_r == C10) begin
              tcur = {b, 8'h00};
            end
            if (cnt_r == C9) begin
              tcur = {rtype_r[15:8], b};
            end
            if (cnt_r == C2) begin
              lcur = {b, 8'h00};
            end
            if (cnt_r == C1) begin
              lcur = {rlen_r[15:8], b};
            end
            cnt_nxt = cnt_dec;
            if (cnt_dec == C0) begin
              // short rdata drops the record type so nothing is emitted
              if ((tcur == TYPE_A && lcur < 16'd4) || (tcur == TYPE_AAAA && lcur < 16'd16)) begin
                tcur = 16'd0;
              end
              if (lcur == 16'd0) begin
                ans_nxt = ans_dec;
                if (ans_dec == C0) begin
                  phase_nxt = PH_DONE;
                end else begin
                  phase_nxt = PH_RFIX;
                  cnt_nxt   = C12;
                end
              end else begin
                phase_nxt  = PH_RDATA;
                cnt_nxt    = C0;
                acc_hi_nxt = 64'd0;
                acc_lo_nxt = 64'd0;
              end
            end
            rtype_nxt = tcur;
            rlen_nxt  = lcur;
          end
          PH_RDATA: begin
            if (cnt_r < C16) begin
              acc_hi_nxt = shift_hi;
              acc_lo_nxt = shift_lo;
              cnt_nxt    = cnt_r + C1;
            end
            rlen_nxt = rlen_dec;
            if (rlen_dec == 16'd0) begin
              ans_nxt = ans_dec;
              if (ans_dec == C0) begin
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt = PH_RFIX;
                cnt_nxt   = C12;
              end
            end
          end
          default: begin
          end
        endcase
      end
      if (word.last_byte) begin
        phase_nxt = PH_IDLE;
      end
    end
  end

  // outputs
  always_comb begin
    res_valid       = 1'b0;
    res.kind        = KIND_END;
    res.addr_high   = 64'd0;
    res.addr_low    = 64'd0;
    res.out_tag     = word.first_byte ? (word.set_tag & TAG_MASK) : tag_r;
    res.packet_done = word.last_byte;
    if (step) begin
      if (word.first_byte) begin
        res_valid = word.last_byte;
      end else if (phase_r != PH_IDLE) begin
        res_valid = rdy4 || rdy6 || word.last_byte;
      end
    end
    if (rdy4) begin
      res.kind     = KIND_V4;
      res.addr_low = {32'd0, shift_lo[31:0]};
    end else if (rdy6) begin
      res.kind      = KIND_V6;
      res.addr_high = shift_hi;
      res.addr_low  = shift_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= C0;
      ans_r   <= C0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      ans_r   <= ans_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ans_hi_r <= ans_hi_nxt;
    qtype_r  <= qtype_nxt;
    rtype_r  <= rtype_nxt;
    rlen_r   <= rlen_nxt;
    acc_hi_r <= acc_hi_nxt;
    acc_lo_r <= acc_lo_nxt;
    tag_r    <= tag_nxt;
  end

  a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && word.last_byte |=> phase_r == PH_IDLE)
    else $error("parser not idle after packet end");

  a_end_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.kind == KIND_END |-> res.packet_done)
    else $error("end result without last byte");

  a_v4_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.kind == KIND_V4 |-> res.addr_high == 64'd0 && res.addr_low[63:32] == 32'd0)
    else $error("ipv4 result with upper bits set");

  a_addr_in_rdata: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (res.kind == KIND_V4 || res.kind == KIND_V6) |-> phase_r == PH_RDATA)
    else $error("address result outside record data");

endmodule

// ===== rtl/dnsx_out_reg.sv =====
// dnsx_out_reg: result register with valid/ready handshake toward the receiver
// depends on dnsx_pkg
`timescale 1ns / 1ps

module dnsx_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  input  dnsx_pkg::res_t   res,
  output logic             advance,
  output logic             out_valid,
  input  logic             out_ready,
  output dnsx_pkg::res_t   out_word
);
  import dnsx_pkg::*;

  logic out_valid_r;
  res_t out_r;

  assign advance   = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_r <= res;
    end
  end

endmodule

// ===== rtl/dns_answer_address_extractor.sv =====
// dns_answer_address_extractor: top level that pulls a and aaaa addresses out of dns responses
// depends on dnsx_pkg, dnsx_if, dnsx_in_reg, dnsx_parser, dnsx_out_reg
//
// in_ch takes one packet word per cycle while in_ch.ready is high, starting at the ip
// header; first_byte marks a packet start (and samples set_tag), last_byte marks its end
// out_ch gives one word per extracted address: kind v4 or v6 with the address,
// or kind end on the last byte of a packet when no address finishes there;
// packet_done is set when the word coincides with the packet's last byte
// the input register loads at the accept edge, then parse logic feeds the result
// register; throughput: one packet word per cycle while out_ch is not stalled, and
// most words produce no output word
// the two registers decouple the sides, so input is taken while a result
// waits; when out_ch.ready stays low both registers fill and in_ch.ready drops
// reset (rst_n low, synchronous) empties both registers and returns the parser
// to idle; words without first_byte are dropped until a packet starts
`timescale 1ns / 1ps

module dns_answer_address_extractor #(
  parameter int COUNT_WIDTH = dnsx_pkg::COUNT_WIDTH_DEF
) (
  input logic             clk,
  input logic             rst_n,
  dnsx_in_if.sink         in_ch,
  dnsx_out_if.source      out_ch
);
  import dnsx_pkg::*;

  in_word_t in_word, word;
  res_t     res, out_word;
  logic     in_ready, step, advance, res_valid, out_valid;

  assign in_word.data_byte  = in_ch.data_byte;
  assign in_word.set_tag    = in_ch.set_tag;
  assign in_word.first_byte = in_ch.first_byte;
  assign in_word.last_byte  = in_ch.last_byte;
  assign in_ch.ready        = in_ready;

  dnsx_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_word  (in_word),
    .in_ready (in_ready),
    .advance  (advance),
    .step     (step),
    .word     (word)
  );

  dnsx_parser #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .word      (word),
    .res_valid (res_valid),
    .res       (res)
  );

  dnsx_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_word  (out_word)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.kind        = out_word.kind;
  assign out_ch.addr_high   = out_word.addr_high;
  assign out_ch.addr_low    = out_word.addr_low;
  assign out_ch.out_tag     = out_word.out_tag;
  assign out_ch.packet_done = out_word.packet_done;

endmodule
